// File: hdl/cmfs_pkg.sv
// shared types and constants for the cube map face selection block
package cmfs_pkg;

  // width of each direction component (signed, Q1.15 at the default)
  localparam int COMP_BITS = 16;

  // coordinate format: unsigned Q0.16, quotient carries one extra bit for 1.0
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = COORD_BITS - 1;
  localparam int Q_BITS     = COORD_BITS + 1;

  // divider stages: integer step plus one stage per fraction bit
  localparam int DIV_LAT = FRAC_BITS + 1;

  localparam int FACE_BITS = 3;

  localparam logic [FACE_BITS-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_BITS-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_BITS-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_BITS-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_BITS-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_BITS-1:0] FACE_NEG_Z = 3'd5;

  // one half in Q0.16, and the saturated top code
  localparam logic [COORD_BITS-1:0] COORD_HALF = 16'h8000;
  localparam logic [COORD_BITS-1:0] COORD_MAX  = 16'hFFFF;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] dir_x;
    logic signed [COMP_BITS-1:0] dir_y;
    logic signed [COMP_BITS-1:0] dir_z;
  } cmfs_in_t;

  typedef struct packed {
    logic [FACE_BITS-1:0]  face;
    logic [COORD_BITS-1:0] coord_u;
    logic [COORD_BITS-1:0] coord_v;
    logic                  degenerate;
  } cmfs_out_t;

  // per-item sideband that rides alongside the divider
  typedef struct packed {
    logic [FACE_BITS-1:0] face;
    logic                 degenerate;
  } cmfs_side_t;

endpackage

// File: hdl/cmfs_div.sv
// pipelined restoring divider: floor(num * 2^15 / den), integer step then one fraction bit per stage
module cmfs_div (
  input  logic                                  clk,
  input  logic [cmfs_pkg::COMP_BITS:0]          num,
  input  logic [cmfs_pkg::COMP_BITS-1:0]        den,
  output logic [cmfs_pkg::Q_BITS-1:0]           quot
);

  localparam int W = cmfs_pkg::COMP_BITS;
  localparam int F = cmfs_pkg::FRAC_BITS;
  localparam int Q = cmfs_pkg::Q_BITS;

  logic [W-1:0] rem_r [0:F];
  logic [W-1:0] rem_nxt [0:F];
  logic [W-1:0] den_r [0:F];
  logic [Q-1:0] quot_r [0:F];
  logic [Q-1:0] quot_nxt [0:F];

  logic [W:0] den_ext;
  logic [W:0] den_dbl;
  logic [W:0] rem2;

  always_comb begin
    // integer part is 0, 1 or 2 since num never exceeds twice den
    den_ext = {1'b0, den};
    den_dbl = {den, 1'b0};
    quot_nxt[0] = '0;
    if (num >= den_dbl) begin
      quot_nxt[0][Q-1] = 1'b1;
      rem_nxt[0]       = '0;
    end else if (num >= den_ext) begin
      quot_nxt[0][Q-2] = 1'b1;
      rem_nxt[0]       = W'(num - den_ext);
    end else begin
      rem_nxt[0] = W'(num);
    end

    rem2 = '0;
    for (int k = 1; k <= F; k++) begin
      rem2        = {rem_r[k-1], 1'b0};
      quot_nxt[k] = quot_r[k-1];
      if (rem2 >= {1'b0, den_r[k-1]}) begin
        rem_nxt[k]        = W'(rem2 - {1'b0, den_r[k-1]});
        quot_nxt[k][F-k]  = 1'b1;
      end else begin
        rem_nxt[k] = W'(rem2);
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= rem_nxt[0];
    quot_r[0] <= quot_nxt[0];
    den_r[0]  <= den;
    for (int k = 1; k <= F; k++) begin
      rem_r[k]  <= rem_nxt[k];
      quot_r[k] <= quot_nxt[k];
      den_r[k]  <= den_r[k-1];
    end
  end

  assign quot = quot_r[F];

endmodule

// File: hdl/cube_map_face_select.sv
// top level of the cube map face selection pipeline
//
// takes one direction vector per cycle and returns its cube face and the
// (u, v) face coordinates in unsigned Q0.16. busy is high only while reset
// is applied and for the cycle after it; otherwise a transfer is taken on
// every clock with start high. each result appears on out_data for exactly
// one cycle with out_valid high; the receiver cannot hold it off. between
// input and output lie the magnitude stage, the face select stage, the two
// coordinate dividers (16 stages: an integer step, then one fraction bit
// per stage) and the output register. a zero vector selects +Z, reports
// degenerate and returns one half for u and v; a coordinate of exactly 1.0
// saturates to the top code.
module cube_map_face_select (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cmfs_pkg::cmfs_in_t  in_data,
  output logic                out_valid,
  output cmfs_pkg::cmfs_out_t out_data
);

  localparam int W = cmfs_pkg::COMP_BITS;
  localparam int L = cmfs_pkg::DIV_LAT;

  // ---------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------
  logic busy_r;
  logic in_xfer;

  assign busy    = busy_r;
  assign in_xfer = start & ~busy_r;

  // ---------------------------------------------------------------------
  // stage a: register components and their magnitudes
  // ---------------------------------------------------------------------
  logic                valid_a_r;
  logic signed [W-1:0] x_a_r, y_a_r, z_a_r;
  logic [W-1:0]        ax_a_r, ay_a_r, az_a_r;
  logic [W-1:0]        ax_nxt, ay_nxt, az_nxt;

  // two's complement negate of the most negative value lands on 2^(W-1),
  // which is the right magnitude when read unsigned
  always_comb begin
    ax_nxt = in_data.dir_x[W-1] ? W'(~in_data.dir_x + 1'b1) : W'(in_data.dir_x);
    ay_nxt = in_data.dir_y[W-1] ? W'(~in_data.dir_y + 1'b1) : W'(in_data.dir_y);
    az_nxt = in_data.dir_z[W-1] ? W'(~in_data.dir_z + 1'b1) : W'(in_data.dir_z);
  end

  // ---------------------------------------------------------------------
  // stage b: pick the major axis, apply face signs, form numerators
  // ---------------------------------------------------------------------
  logic                          valid_b_r;
  cmfs_pkg::cmfs_side_t          side_b_r, side_b_nxt;
  logic [W-1:0]                  major_b_r, major_nxt;
  logic [W:0]                    num_u_b_r, num_v_b_r, num_u_nxt, num_v_nxt;

  logic signed [W:0] xe, ye, ze;
  logic signed [W:0] su, sv;
  logic              z_major, y_major;

  always_comb begin
    xe = {x_a_r[W-1], x_a_r};
    ye = {y_a_r[W-1], y_a_r};
    ze = {z_a_r[W-1], z_a_r};

    // ties go to z, then y
    z_major = (az_a_r >= ax_a_r) && (az_a_r >= ay_a_r);
    y_major = (ay_a_r >= ax_a_r);

    if (z_major) begin
      side_b_nxt.face = z_a_r[W-1] ? cmfs_pkg::FACE_NEG_Z : cmfs_pkg::FACE_POS_Z;
      major_nxt       = az_a_r;
      su              = z_a_r[W-1] ? -xe : xe;
      sv              = -ye;
    end else if (y_major) begin
      side_b_nxt.face = y_a_r[W-1] ? cmfs_pkg::FACE_NEG_Y : cmfs_pkg::FACE_POS_Y;
      major_nxt       = ay_a_r;
      su              = xe;
      sv              = y_a_r[W-1] ? -ze : ze;
    end else begin
      side_b_nxt.face = x_a_r[W-1] ? cmfs_pkg::FACE_NEG_X : cmfs_pkg::FACE_POS_X;
      major_nxt       = ax_a_r;
      su              = x_a_r[W-1] ? ze : -ze;
      sv              = -ye;
    end

    side_b_nxt.degenerate = (major_nxt == '0);

    // major + minor lies in 0 .. 2*major, so the W+1 bit sum is exact
    num_u_nxt = (W + 1)'({1'b0, major_nxt} + su);
    num_v_nxt = (W + 1)'({1'b0, major_nxt} + sv);
  end

  // ---------------------------------------------------------------------
  // dividers: 32768 * num / major, one per coordinate
  // ---------------------------------------------------------------------
  logic [cmfs_pkg::Q_BITS-1:0] quot_u, quot_v;

  cmfs_div u_div_u (
    .clk  (clk),
    .num  (num_u_b_r),
    .den  (major_b_r),
    .quot (quot_u)
  );

  cmfs_div u_div_v (
    .clk  (clk),
    .num  (num_v_b_r),
    .den  (major_b_r),
    .quot (quot_v)
  );

  // face and degenerate flag follow the dividers through a matching delay line
  logic                 valid_d_r [0:L-1];
  cmfs_pkg::cmfs_side_t side_d_r  [0:L-1];

  // ---------------------------------------------------------------------
  // output register: saturate 1.0, force one half on a zero vector
  // ---------------------------------------------------------------------
  logic                out_valid_r;
  cmfs_pkg::cmfs_out_t out_r, out_nxt;

  function automatic logic [cmfs_pkg::COORD_BITS-1:0] sat_coord(
    input logic [cmfs_pkg::Q_BITS-1:0] q
  );
    if (q[cmfs_pkg::Q_BITS-1]) begin
      return cmfs_pkg::COORD_MAX;
    end
    return q[cmfs_pkg::COORD_BITS-1:0];
  endfunction

  always_comb begin
    out_nxt.face       = side_d_r[L-1].face;
    out_nxt.degenerate = side_d_r[L-1].degenerate;
    if (side_d_r[L-1].degenerate) begin
      out_nxt.coord_u = cmfs_pkg::COORD_HALF;
      out_nxt.coord_v = cmfs_pkg::COORD_HALF;
    end else begin
      out_nxt.coord_u = sat_coord(quot_u);
      out_nxt.coord_v = sat_coord(quot_v);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------
  // valid bits: reset raises busy and clears them
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      valid_a_r   <= 1'b0;
      valid_b_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < L; k++) begin
        valid_d_r[k] <= 1'b0;
      end
    end else begin
      busy_r       <= 1'b0;
      valid_a_r    <= in_xfer;
      valid_b_r    <= valid_a_r;
      valid_d_r[0] <= valid_b_r;
      for (int k = 1; k < L; k++) begin
        valid_d_r[k] <= valid_d_r[k-1];
      end
      out_valid_r <= valid_d_r[L-1];
    end
  end

  // ---------------------------------------------------------------------
  // payload registers: no reset needed
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    x_a_r  <= in_data.dir_x;
    y_a_r  <= in_data.dir_y;
    z_a_r  <= in_data.dir_z;
    ax_a_r <= ax_nxt;
    ay_a_r <= ay_nxt;
    az_a_r <= az_nxt;

    side_b_r  <= side_b_nxt;
    major_b_r <= major_nxt;
    num_u_b_r <= num_u_nxt;
    num_v_b_r <= num_v_nxt;

    side_d_r[0] <= side_b_r;
    for (int k = 1; k < L; k++) begin
      side_d_r[k] <= side_d_r[k-1];
    end

    out_r <= out_nxt;
  end

endmodule

// File: bench/cube_map_face_select_test.sv
// self-checking testbench for the cube map face selection pipeline
`timescale 1ns / 1ps

module cube_map_face_select_test;
  import cmfs_pkg::*;

  localparam int CLK_HALF_NS  = 2;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1850;
  // drain wait covers the divider depth with some slack past it
  localparam int DRAIN_CYCLES = DIV_LAT + 12;
  localparam int DRAIN_LIMIT  = 5000;
  // worst case is ~1900 transfers at the longest gap with a 4 ns clock, about 122 us
  localparam int RUN_LIMIT_NS = 2_000_000;
  localparam int MAX_REPORTS  = 40;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  cmfs_in_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  cmfs_out_t out_data;

  // one directed vector; want is only meaningful when typed_in is set
  typedef struct {
    cmfs_in_t  dir;
    bit        typed_in;
    cmfs_out_t want;
  } dir_case_t;

  dir_case_t   directed_cases[$];
  // face and coordinates still owed by the pipeline, oldest first
  cmfs_out_t   face_coords_due[$];
  int unsigned mismatches     = 0;
  int unsigned results_seen   = 0;
  int unsigned transfers_sent = 0;
  int unsigned zero_vectors   = 0;
  int unsigned face_hits[6]   = '{default: 0};

  always begin
    clk = 1'b1;
    #CLK_HALF_NS;
    clk = 1'b0;
    #CLK_HALF_NS;
  end

  cube_map_face_select u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // floor(32768 * (major + minor) / major), with 1.0 clamped to the top code
  function automatic logic [COORD_BITS-1:0] face_coord_q16(longint major, longint minor);
    longint c;
    c = ((major + minor) <<< FRAC_BITS) / major;
    if (c > longint'(COORD_MAX)) c = longint'(COORD_MAX);
    return c[COORD_BITS-1:0];
  endfunction

  // expected face, (u, v) and degenerate flag for one direction
  function automatic cmfs_out_t cube_face_lookup(cmfs_in_t d);
    longint    x, y, z, ax, ay, az, major, su, sv;
    cmfs_out_t r;
    x  = longint'(d.dir_x);
    y  = longint'(d.dir_y);
    z  = longint'(d.dir_z);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    // z wins every tie, then y
    if (az >= ax && az >= ay) begin
      r.face = (z < 0) ? FACE_NEG_Z : FACE_POS_Z;
      major  = az;
      su     = (z < 0) ? -x : x;
      sv     = -y;
    end else if (ay >= ax) begin
      r.face = (y < 0) ? FACE_NEG_Y : FACE_POS_Y;
      major  = ay;
      su     = x;
      sv     = (y < 0) ? -z : z;
    end else begin
      r.face = (x < 0) ? FACE_NEG_X : FACE_POS_X;
      major  = ax;
      su     = (x < 0) ? z : -z;
      sv     = -y;
    end
    // zero vector lands on +Z with both coordinates at one half
    if (major == 0) begin
      r.coord_u    = COORD_HALF;
      r.coord_v    = COORD_HALF;
      r.degenerate = 1'b1;
    end else begin
      r.coord_u    = face_coord_q16(major, su);
      r.coord_v    = face_coord_q16(major, sv);
      r.degenerate = 1'b0;
    end
    return r;
  endfunction

  function automatic void add_case(int x, int y, int z, bit typed_in,
                                   logic [FACE_BITS-1:0] face = FACE_POS_Z,
                                   logic [COORD_BITS-1:0] u = COORD_HALF,
                                   logic [COORD_BITS-1:0] v = COORD_HALF,
                                   logic degen = 1'b0);
    dir_case_t c;
    c.dir.dir_x        = x[COMP_BITS-1:0];
    c.dir.dir_y        = y[COMP_BITS-1:0];
    c.dir.dir_z        = z[COMP_BITS-1:0];
    c.typed_in         = typed_in;
    c.want.face        = face;
    c.want.coord_u     = u;
    c.want.coord_v     = v;
    c.want.degenerate  = degen;
    directed_cases.push_back(c);
  endfunction

  // component of magnitude m with a random sign; 32768 only exists negative
  function automatic int signed_comp(int m);
    if (m == 32768) return -32768;
    return ($urandom_range(0, 1) != 0) ? -m : m;
  endfunction

  function automatic cmfs_in_t draw_direction();
    cmfs_in_t    d;
    int          comp[3];
    int          a;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) comp[i] = int'(shortint'($urandom));
    if (mode >= 4 && mode <= 5) begin
      // tiny values: ties and the smallest majors are frequent
      for (int i = 0; i < 3; i++) comp[i] = int'($urandom_range(0, 8)) - 4;
    end else if (mode >= 6 && mode <= 7) begin
      // shared magnitude on some axes, the rest strictly smaller
      a = int'($urandom_range(1, 32768));
      for (int i = 0; i < 3; i++) begin
        if ($urandom_range(0, 2) != 0) comp[i] = signed_comp(a);
        else comp[i] = signed_comp(int'($urandom_range(0, a - 1)));
      end
    end else if (mode == 8) begin
      // one axis pinned at full scale, either end
      comp[$urandom_range(0, 2)] = ($urandom_range(0, 1) != 0) ? -32768 : 32767;
    end else if (mode == 9) begin
      // sparse vectors, the all-zero case among them
      a = comp[0];
      comp = '{0, 0, 0};
      if ($urandom_range(0, 2) != 0) comp[$urandom_range(0, 2)] = a;
    end
    d.dir_x = comp[0][COMP_BITS-1:0];
    d.dir_y = comp[1][COMP_BITS-1:0];
    d.dir_z = comp[2][COMP_BITS-1:0];
    return d;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // keep start low for the requested gap, then hold start until a transfer is taken
  task automatic issue_direction(cmfs_in_t d, cmfs_out_t want, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    // transfer taken at this edge; its result is still in the pipeline, so the
    // push cannot race a pop by the result checker in the same step
    face_coords_due.push_back(want);
    transfers_sent++;
    if (want.face <= FACE_NEG_Z) face_hits[want.face]++;
    if (want.degenerate) zero_vectors++;
  endtask

  // result checker: every strobe must match the oldest outstanding expectation
  always @(posedge clk) begin
    cmfs_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (face_coords_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_seen));
      end else begin
        want = face_coords_due.pop_front();
        if (out_data.face !== want.face)
          report_mismatch($sformatf("result %0d face got %0d want %0d",
                                    results_seen, out_data.face, want.face));
        if (out_data.coord_u !== want.coord_u)
          report_mismatch($sformatf("result %0d coord_u got %0d want %0d",
                                    results_seen, out_data.coord_u, want.coord_u));
        if (out_data.coord_v !== want.coord_v)
          report_mismatch($sformatf("result %0d coord_v got %0d want %0d",
                                    results_seen, out_data.coord_v, want.coord_v));
        if (out_data.degenerate !== want.degenerate)
          report_mismatch($sformatf("result %0d degenerate got %0b want %0b",
                                    results_seen, out_data.degenerate, want.degenerate));
      end
    end
  end

  initial begin : stimulus
    cmfs_in_t d;
    int       gap;
    int       burst_left;
    int       drained;

    // directed vectors; typed-in rows are the ones readable at a glance
    add_case(0, 0, 0, 1, FACE_POS_Z, COORD_HALF, COORD_HALF, 1'b1);   // zero vector
    add_case(32767, 0, 0, 1, FACE_POS_X, COORD_HALF, COORD_HALF);      // pure axes
    add_case(-32768, 0, 0, 1, FACE_NEG_X, COORD_HALF, COORD_HALF);
    add_case(0, 32767, 0, 1, FACE_POS_Y, COORD_HALF, COORD_HALF);
    add_case(0, -32768, 0, 1, FACE_NEG_Y, COORD_HALF, COORD_HALF);
    add_case(0, 0, 32767, 1, FACE_POS_Z, COORD_HALF, COORD_HALF);
    add_case(0, 0, -32768, 1, FACE_NEG_Z, COORD_HALF, COORD_HALF);
    add_case(32767, 32767, 32767, 1, FACE_POS_Z, COORD_MAX, '0);       // three-way tie, 1.0 clamps
    add_case(-32768, -32768, -32768, 1, FACE_NEG_Z, COORD_MAX, COORD_MAX);
    add_case(1000, 1000, 0, 1, FACE_POS_Y, COORD_MAX, COORD_HALF);     // x/y tie goes to y
    add_case(-1000, 1000, 0, 1, FACE_POS_Y, '0, COORD_HALF);
    add_case(1, 0, 0, 0);
    add_case(0, 0, -1, 0);
    add_case(-1, -1, -1, 0);
    add_case(0, 1, -1, 0);
    add_case(-32768, 32767, 0, 0);
    add_case(32767, -32768, 100, 0);
    add_case(300, -32768, -32768, 0);
    add_case(32767, -32767, 5, 0);
    add_case(12345, -5000, 3000, 0);
    add_case(-20000, 15000, -19999, 0);
    add_case(-7, 7, -7, 0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_cases[i]) begin
      issue_direction(directed_cases[i].dir,
                      directed_cases[i].typed_in ? directed_cases[i].want
                                                 : cube_face_lookup(directed_cases[i].dir),
                      int'($urandom_range(0, 3)));
    end

    // random part: random per-transfer gaps, broken up by back-to-back bursts
    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else if ($urandom_range(0, 15) == 0) begin
        gap        = 0;
        burst_left = int'($urandom_range(8, 64));
      end else begin
        gap = int'($urandom_range(0, 15));
      end
      d = draw_direction();
      issue_direction(d, cube_face_lookup(d), gap);
    end
    @(negedge clk);
    start <= 1'b0;

    // wait for the pipeline to empty, then a little longer for strays
    drained = 0;
    while (face_coords_due.size() != 0 && drained < DRAIN_LIMIT) begin
      @(posedge clk);
      drained++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (face_coords_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", face_coords_due.size()));

    $display("sent %0d direction transfers, checked %0d results, %0d zero vectors",
             transfers_sent, results_seen, zero_vectors);
    $display("face counts +X %0d -X %0d +Y %0d -Y %0d +Z %0d -Z %0d, %0d mismatches",
             face_hits[0], face_hits[1], face_hits[2], face_hits[3], face_hits[4],
             face_hits[5], mismatches);
    if (mismatches == 0) begin
      $display("cube_map_face_select_test OK");
    end else begin
      $display("cube_map_face_select_test NOT OK");
    end
    $finish;
  end

  // hard stop in case a handshake never completes
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("run limit hit with %0d results outstanding", face_coords_due.size());
    $display("cube_map_face_select_test NOT OK");
    $finish;
  end

endmodule
